FILE: src/mtra_pkg.sv
// Shared constants, result codes and controller/datapath handshake types.
`default_nettype none

package mtra_pkg;

  localparam int MAX_CONTACTS_DEF = 4;

  localparam logic [7:0] ID_VENDOR = 8'h03;
  localparam logic [7:0] ID_MTOUCH = 8'h04;

  localparam int CID_W   = 5;  // contact number field width
  localparam int CID_LSB = 2;
  localparam int STATUS_BIT = 0;
  localparam int POS_W   = 12;
  localparam int POS_LSB = 4;
  localparam int TID_W   = 2;

  localparam logic [1:0] KIND_CONTACT = 2'd0;
  localparam logic [1:0] KIND_NONE    = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  typedef struct packed {
    logic store;
    logic scan_clear;
    logic scan_next;
    logic load_contact;
    logic load_none;
    logic load_reject;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic vendor;
    logic do_frame;
    logic any_pressed;
    logic cur_pressed;
    logic more_above;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/mtra_if.sv
// Input and result channel interfaces.
`default_nettype none

interface mtra_in_if;
  logic       valid;
  logic       ready;
  logic       read_ok;
  logic [7:0] report_id;
  logic [7:0] contact_byte;
  logic [15:0] x_word;
  logic [15:0] y_word;

  modport source(output valid, read_ok, report_id, contact_byte, x_word, y_word,
                 input ready);
  modport sink(input valid, read_ok, report_id, contact_byte, x_word, y_word,
               output ready);
endinterface

interface mtra_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  tracking_id;
  logic        pressure;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic        frame_last;

  modport source(output valid, kind, tracking_id, pressure, pos_x, pos_y, frame_last,
                 input ready);
  modport sink(input valid, kind, tracking_id, pressure, pos_x, pos_y, frame_last,
               output ready);
endinterface

`default_nettype wire

FILE: src/mtra_datapath.sv
// Report decode, contact slot table, slot scan index and result register.
`default_nettype none

module mtra_datapath import mtra_pkg::*; #(
  parameter int MAX_CONTACTS = MAX_CONTACTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              read_ok,
  input  wire logic [7:0]        report_id,
  input  wire logic [7:0]        contact_byte,
  input  wire logic [15:0]       x_word,
  input  wire logic [15:0]       y_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             kind,
  output logic [TID_W-1:0]       tracking_id,
  output logic                   pressure,
  output logic [POS_W-1:0]       pos_x,
  output logic [POS_W-1:0]       pos_y,
  output logic                   frame_last,
  input  wire dp_cmd_t           cmd,
  output dp_status_t             st
);

  localparam int SLOT_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

  logic [POS_W-1:0]        slot_x_r [MAX_CONTACTS];
  logic [POS_W-1:0]        slot_y_r [MAX_CONTACTS];
  logic [MAX_CONTACTS-1:0] pressed_r;
  logic [SLOT_W-1:0]       last_contact_r;
  logic [SLOT_W-1:0]       scan_idx_r;

  logic                    out_valid_r;
  logic [1:0]              kind_r;
  logic [TID_W-1:0]        tid_r;
  logic                    pressure_r;
  logic [POS_W-1:0]        pos_x_r;
  logic [POS_W-1:0]        pos_y_r;
  logic                    last_r;

  logic [CID_W-1:0]        cid;
  logic                    status;
  logic                    in_range;
  logic [SLOT_W-1:0]       wr_idx;
  logic [MAX_CONTACTS-1:0] above_mask;

  assign cid      = contact_byte[CID_LSB +: CID_W];
  assign status   = contact_byte[STATUS_BIT];
  assign in_range = {1'b0, cid} < (CID_W+1)'(MAX_CONTACTS);
  assign wr_idx   = cid[SLOT_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      above_mask[i] = SLOT_W'(i) > scan_idx_r;
    end
  end

  assign st.reject      = !read_ok || ((report_id != ID_VENDOR) && (report_id != ID_MTOUCH))
                          || ((report_id == ID_MTOUCH) && !in_range);
  assign st.vendor      = read_ok && (report_id == ID_VENDOR);
  assign st.do_frame    = !status || (cid <= CID_W'(last_contact_r));
  assign st.any_pressed = |pressed_r;
  assign st.cur_pressed = pressed_r[scan_idx_r];
  assign st.more_above  = |(pressed_r & above_mask);
  assign st.out_free    = !out_valid_r || out_ready;

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r      <= '0;
      last_contact_r <= '0;
    end else if (cmd.store) begin
      pressed_r[wr_idx] <= status;
      last_contact_r    <= wr_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      slot_x_r[wr_idx] <= x_word[POS_LSB +: POS_W];
      slot_y_r[wr_idx] <= y_word[POS_LSB +: POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_clear) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_next) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_contact || cmd.load_none || cmd.load_reject) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_contact) begin
      kind_r     <= KIND_CONTACT;
      tid_r      <= TID_W'(scan_idx_r);
      pressure_r <= 1'b1;
      pos_x_r    <= slot_x_r[scan_idx_r];
      pos_y_r    <= slot_y_r[scan_idx_r];
      last_r     <= !st.more_above;
    end else if (cmd.load_none || cmd.load_reject) begin
      kind_r     <= cmd.load_none ? KIND_NONE : KIND_REJECT;
      tid_r      <= '0;
      pressure_r <= 1'b0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      last_r     <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign kind        = kind_r;
  assign tracking_id = tid_r;
  assign pressure    = pressure_r;
  assign pos_x       = pos_x_r;
  assign pos_y       = pos_y_r;
  assign frame_last  = last_r;

endmodule

`default_nettype wire

FILE: src/mtra_ctrl.sv
// Controller: item intake, slot scan sequencing and result loading.
`default_nettype none

module mtra_ctrl import mtra_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REJECT,
    ST_SCAN,
    ST_NONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   accept;

  assign accept = in_valid && in_ready_r;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (st.reject) begin
            state_nxt    = ST_REJECT;
            in_ready_nxt = 1'b0;
          end else if (!st.vendor) begin
            cmd.store = 1'b1;
            if (st.do_frame) begin
              cmd.scan_clear = 1'b1;
              state_nxt      = ST_SCAN;
              in_ready_nxt   = 1'b0;
            end
          end
        end
      end
      ST_REJECT, ST_NONE: begin
        if (st.out_free) begin
          cmd.load_reject = (state_r == ST_REJECT);
          cmd.load_none   = (state_r == ST_NONE);
          state_nxt       = ST_IDLE;
          in_ready_nxt    = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!st.any_pressed) begin
          state_nxt = ST_NONE;
        end else if (!st.cur_pressed) begin
          cmd.scan_next = 1'b1;
        end else if (st.out_free) begin
          cmd.load_contact = 1'b1;
          if (st.more_above) begin
            cmd.scan_next = 1'b1;
          end else begin
            state_nxt    = ST_IDLE;
            in_ready_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

FILE: src/multitouch_report_assembler.sv
// Top level of the multitouch report assembler.
`default_nettype none

// Takes one touch report per item and turns multitouch reports into frames of
// contact results. An item is taken when the block is idle; a vendor packet
// or a contact update that closes no frame frees the input at once, a
// rejected report holds it until its reject result is loaded. A report that
// closes a frame starts a scan of the slot table, one slot per cycle (holding
// at a pressed slot while the output register is full) from slot 0 up to the
// highest pressed slot, loading one result per pressed slot into the output
// register, or one no-contact result if none is pressed. A result register on
// the output lets the next item be accepted while a frame's last result waits.
module multitouch_report_assembler import mtra_pkg::*; #(
  parameter int MAX_CONTACTS = MAX_CONTACTS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mtra_in_if.sink    in_ch,
  mtra_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t st;

  mtra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mtra_datapath #(
    .MAX_CONTACTS (MAX_CONTACTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .read_ok      (in_ch.read_ok),
    .report_id    (in_ch.report_id),
    .contact_byte (in_ch.contact_byte),
    .x_word       (in_ch.x_word),
    .y_word       (in_ch.y_word),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .kind         (out_ch.kind),
    .tracking_id  (out_ch.tracking_id),
    .pressure     (out_ch.pressure),
    .pos_x        (out_ch.pos_x),
    .pos_y        (out_ch.pos_y),
    .frame_last   (out_ch.frame_last),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

`default_nettype wire

FILE: src/mtra_checker.sv
// Port-level checks for the multitouch report assembler, bound to the top level.
`default_nettype none

module mtra_checker import mtra_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [1:0]  tracking_id,
  input wire logic        pressure,
  input wire logic [11:0] pos_x,
  input wire logic [11:0] pos_y,
  input wire logic        frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(kind) && $stable(tracking_id) && $stable(pos_x)
      && $stable(pos_y) && $stable(frame_last))
    else $error("stalled result changed");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_NONE || kind == KIND_REJECT) |->
      frame_last && !pressure && tracking_id == 2'd0 && pos_x == 12'd0 && pos_y == 12'd0)
    else $error("bad no-contact or rejected result");

  a_contact_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_CONTACT |-> pressure)
    else $error("contact result for released slot");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind multitouch_report_assembler mtra_checker u_mtra_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .tracking_id (out_ch.tracking_id),
  .pressure    (out_ch.pressure),
  .pos_x       (out_ch.pos_x),
  .pos_y       (out_ch.pos_y),
  .frame_last  (out_ch.frame_last)
);

`default_nettype wire
